FILE: src/cube_face_orientation_qualifier_defines.svh
// ----------------------------------------------------------------------------
// Cube face orientation qualifier: assertion macros
// Shared macros for the concurrent checks used in the qualifier RTL.
// ----------------------------------------------------------------------------
`ifndef CUBE_FACE_ORIENTATION_QUALIFIER_DEFINES_SVH
`define CUBE_FACE_ORIENTATION_QUALIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CFOQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CFOQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/cfoq_pkg.sv
// ----------------------------------------------------------------------------
// Cube face orientation qualifier package
// Payload types, register map, face codes and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cfoq_pkg;

   // Default width of the kept timestamps.
   localparam int TIME_BITS_DEFAULT = 32;

   // Face codes.
   localparam logic [2:0] FACE_X_POS = 3'd0;
   localparam logic [2:0] FACE_X_NEG = 3'd1;
   localparam logic [2:0] FACE_Y_POS = 3'd2;
   localparam logic [2:0] FACE_Y_NEG = 3'd3;
   localparam logic [2:0] FACE_Z_POS = 3'd4;
   localparam logic [2:0] FACE_Z_NEG = 3'd5;
   localparam logic [2:0] FACE_NONE  = 3'd6;

   // Register reset values.
   localparam logic [15:0] STILL_THRESHOLD_RESET = 16'd300;
   localparam logic [15:0] FACE_FLOOR_RESET      = 16'd1500;

   // Item kind.
   typedef enum logic {
      MODE_SAMPLE = 1'b0,
      MODE_WAKE   = 1'b1
   } mode_type;

   // Register indexes.
   typedef enum logic [2:0] {
      CSR_GYRO_OFFSET_X   = 3'd0,
      CSR_GYRO_OFFSET_Y   = 3'd1,
      CSR_GYRO_OFFSET_Z   = 3'd2,
      CSR_STILL_THRESHOLD = 3'd3,
      CSR_FACE_FLOOR      = 3'd4,
      CSR_SETTLE_TIME_MS  = 3'd5,
      CSR_SLEEP_DELAY_MS  = 3'd6,
      CSR_SLEEP_ENABLE    = 3'd7
   } csr_index_type;

   // One input beat.
   typedef struct packed {
      mode_type           mode;
      logic [31:0]        time_ms;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic       still;
      logic [2:0] detected_face;
      logic [2:0] stable_face;
      logic       face_report;
      logic       sleep_request;
   } rsp_type;

   // Configuration register set.
   typedef struct packed {
      logic signed [15:0] gyro_offset_x;
      logic signed [15:0] gyro_offset_y;
      logic signed [15:0] gyro_offset_z;
      logic [15:0]        still_threshold;
      logic [15:0]        face_floor;
      logic [15:0]        settle_time_ms;
      logic [31:0]        sleep_delay_ms;
      logic               sleep_enable;
   } cfg_type;

   // Magnitude of a 16-bit signed value; the most negative value gives 32768.
   function automatic logic [16:0] mag16(input logic signed [15:0] v);
      logic signed [16:0] w;
      w = 17'(v);
      return w[16] ? 17'(-w) : 17'(w);
   endfunction

endpackage

`default_nettype wire

FILE: src/cfoq_sense.sv
// ----------------------------------------------------------------------------
// Cube face orientation qualifier: sensor evaluation
// Offset-corrects the gyro axes, decides stillness and picks the dominant
// accelerometer face of one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module cfoq_sense (
   input  cfoq_pkg::req_type sample,
   input  cfoq_pkg::cfg_type cfg,
   output logic              still,
   output logic [2:0]        face
);
   import cfoq_pkg::*;

   logic signed [15:0] rate_cx, rate_cy, rate_cz;
   logic [16:0]        gx, gy, gz;
   logic [16:0]        ax, ay, az;
   logic [19:0]        ax4, ay4, az4, ax5, ay5, az5;
   logic               below_floor;
   logic               x_wins, y_wins, z_wins;

   // Gyro offset correction with 16-bit wrap, then the stillness test.
   assign rate_cx = sample.rate_x - cfg.gyro_offset_x;
   assign rate_cy = sample.rate_y - cfg.gyro_offset_y;
   assign rate_cz = sample.rate_z - cfg.gyro_offset_z;
   assign gx = mag16(rate_cx);
   assign gy = mag16(rate_cy);
   assign gz = mag16(rate_cz);
   assign still = (gx < 17'(cfg.still_threshold)) &&
                  (gy < 17'(cfg.still_threshold)) &&
                  (gz < 17'(cfg.still_threshold));

   // Accelerometer magnitudes scaled by four and by five for the 1.25 ratio.
   assign ax  = mag16(sample.accel_x);
   assign ay  = mag16(sample.accel_y);
   assign az  = mag16(sample.accel_z);
   assign ax4 = 20'(ax) << 2;
   assign ay4 = 20'(ay) << 2;
   assign az4 = 20'(az) << 2;
   assign ax5 = ax4 + 20'(ax);
   assign ay5 = ay4 + 20'(ay);
   assign az5 = az4 + 20'(az);

   assign below_floor = (ax < 17'(cfg.face_floor)) &&
                        (ay < 17'(cfg.face_floor)) &&
                        (az < 17'(cfg.face_floor));
   assign x_wins = (ax4 > ay5) && (ax4 > az5);
   assign y_wins = (ay4 > ax5) && (ay4 > az5);
   assign z_wins = (az4 > ax5) && (az4 > ay5);

   // A winning axis always has a nonzero reading, so the sign bit picks the face.
   always_comb begin
      priority if (below_floor) begin
         face = FACE_NONE;
      end else if (x_wins) begin
         face = sample.accel_x[15] ? FACE_X_NEG : FACE_X_POS;
      end else if (y_wins) begin
         face = sample.accel_y[15] ? FACE_Y_NEG : FACE_Y_POS;
      end else if (z_wins) begin
         face = sample.accel_z[15] ? FACE_Z_NEG : FACE_Z_POS;
      end else begin
         face = FACE_NONE;
      end
   end

endmodule

`default_nettype wire

FILE: src/cube_face_orientation_qualifier.sv
// ----------------------------------------------------------------------------
// Cube face orientation qualifier
// Qualifies accelerometer/gyro samples into a settled cube face, raises face
// reports and sleep requests, and handles wake events.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while req_stall is low and returns one
// result beat per input beat, in order. A beat is registered in the input
// register, then in the result register that drives the result channel and
// holds it while the result side stalls. A beat waits in the input register,
// is evaluated in a single pass of compares and adds, and moves into the
// result register; the face, motion and sleep state is updated as the beat
// moves, so the next beat sees it at once. The input register can take a
// beat while a finished result waits, and stall on the input side rises only
// when both registers are full and the result side stalls. Configuration
// writes are taken in every cycle and should be made while no beat is in flight.
`default_nettype none

module cube_face_orientation_qualifier #(
   parameter int TIME_BITS = cfoq_pkg::TIME_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cfoq_pkg::req_type       req_data,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cfoq_pkg::rsp_type       rsp_data,
   // configuration channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  cfoq_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_data
);
   import cfoq_pkg::*;

`include "cube_face_orientation_qualifier_defines.svh"

   localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

   cfg_type              cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   req_type              in_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, rsp_in;
   logic                 advance, accept;

   logic [2:0]           cand_face_ff, cand_face_in;
   logic [TIME_BITS-1:0] cand_since_ff, cand_since_in;
   logic [2:0]           conf_face_ff, conf_face_in;
   logic [2:0]           rep_face_ff, rep_face_in;
   logic [TIME_BITS-1:0] motion_ff, motion_in;
   logic                 asleep_ff, asleep_in;

   logic                 sense_still;
   logic [2:0]           sense_face;
   logic [TIME_BITS-1:0] now, motion_age, cand_age;
   logic                 sleep_hit;
   logic [2:0]           det;

   // Configuration registers, each write masked to the register width.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GYRO_OFFSET_X:   cfg_in.gyro_offset_x   = csr_data[15:0];
            CSR_GYRO_OFFSET_Y:   cfg_in.gyro_offset_y   = csr_data[15:0];
            CSR_GYRO_OFFSET_Z:   cfg_in.gyro_offset_z   = csr_data[15:0];
            CSR_STILL_THRESHOLD: cfg_in.still_threshold = csr_data[15:0];
            CSR_FACE_FLOOR:      cfg_in.face_floor      = csr_data[15:0];
            CSR_SETTLE_TIME_MS:  cfg_in.settle_time_ms  = csr_data[15:0];
            CSR_SLEEP_DELAY_MS:  cfg_in.sleep_delay_ms  = csr_data;
            CSR_SLEEP_ENABLE:    cfg_in.sleep_enable    = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gyro_offset_x   <= '0;
         cfg_ff.gyro_offset_y   <= '0;
         cfg_ff.gyro_offset_z   <= '0;
         cfg_ff.still_threshold <= STILL_THRESHOLD_RESET;
         cfg_ff.face_floor      <= FACE_FLOOR_RESET;
         cfg_ff.settle_time_ms  <= '0;
         cfg_ff.sleep_delay_ms  <= '0;
         cfg_ff.sleep_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Two-register flow: the input register moves on when the result
   // register is empty or its beat is being taken.
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Stillness and face of the beat in the input register.
   cfoq_sense u_sense (
      .sample (in_ff),
      .cfg    (cfg_ff),
      .still  (sense_still),
      .face   (sense_face)
   );

   // Timestamp differences wrap at the kept time width.
   assign now        = TIME_BITS'(in_ff.time_ms);
   assign motion_age = now - motion_ff;
   assign cand_age   = now - cand_since_ff;
   assign sleep_hit  = cfg_ff.sleep_enable && (conf_face_ff != FACE_NONE) &&
                       !asleep_ff &&
                       (CMP_BITS'(motion_age) > CMP_BITS'(cfg_ff.sleep_delay_ms));
   assign det        = sense_still ? sense_face : FACE_NONE;

   // Single-pass evaluation: result and next state of the beat in flight.
   always_comb begin
      cand_face_in  = cand_face_ff;
      cand_since_in = cand_since_ff;
      conf_face_in  = conf_face_ff;
      rep_face_in   = rep_face_ff;
      motion_in     = motion_ff;
      asleep_in     = asleep_ff;
      rsp_in.still         = 1'b0;
      rsp_in.detected_face = FACE_NONE;
      rsp_in.face_report   = 1'b0;
      rsp_in.sleep_request = 1'b0;

      priority if (in_ff.mode == MODE_WAKE) begin
         asleep_in = 1'b0;
         motion_in = now;
      end else if (sleep_hit) begin
         asleep_in            = 1'b1;
         rsp_in.sleep_request = 1'b1;
      end else begin
         rsp_in.still         = sense_still;
         rsp_in.detected_face = det;
         if (!sense_still) begin
            motion_in = now;
         end
         priority if (det == FACE_NONE) begin
            cand_face_in  = FACE_NONE;
            cand_since_in = '0;
         end else if (det != cand_face_ff) begin
            cand_face_in  = det;
            cand_since_in = now;
         end else if ((conf_face_ff != cand_face_ff) &&
                      (cand_age >= TIME_BITS'(cfg_ff.settle_time_ms))) begin
            conf_face_in = cand_face_ff;
            if (cand_face_ff != rep_face_ff) begin
               rep_face_in        = cand_face_ff;
               rsp_in.face_report = 1'b1;
            end
         end
      end
      rsp_in.stable_face = conf_face_in;
   end

   // Face, motion and sleep state, updated as a beat moves to the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_face_ff  <= FACE_NONE;
         cand_since_ff <= '0;
         conf_face_ff  <= FACE_NONE;
         rep_face_ff   <= FACE_NONE;
         motion_ff     <= '0;
         asleep_ff     <= 1'b0;
      end else if (advance) begin
         cand_face_ff  <= cand_face_in;
         cand_since_ff <= cand_since_in;
         conf_face_ff  <= conf_face_in;
         rep_face_ff   <= rep_face_in;
         motion_ff     <= motion_in;
         asleep_ff     <= asleep_in;
      end
   end

   // A sleep request result carries no sample outcome.
   `CFOQ_ASSERT_SAME(a_sleep_clean, clock, reset,
      rsp_valid && rsp_data.sleep_request,
      !rsp_data.still && (rsp_data.detected_face == FACE_NONE) && !rsp_data.face_report,
      "sleep request result carries a sample outcome")

   // A face is only detected on a still sample.
   `CFOQ_ASSERT_SAME(a_face_needs_still, clock, reset,
      rsp_valid && (rsp_data.detected_face != FACE_NONE),
      rsp_data.still,
      "face detected on a moving sample")

   // A report names the face that this very sample confirmed.
   `CFOQ_ASSERT_SAME(a_report_matches, clock, reset,
      rsp_valid && rsp_data.face_report,
      (rsp_data.stable_face == rsp_data.detected_face) &&
      (rsp_data.stable_face != FACE_NONE),
      "face report does not match the confirmed face")

   // A held input beat is still there, unchanged, in the next cycle.
   `CFOQ_ASSERT_NEXT(a_hold_input, clock, reset,
      in_valid_ff && !advance,
      in_valid_ff && $stable(in_ff),
      "held input beat lost")

   // Stall on the input side only while both registers are full and the result side stalls.
   `CFOQ_ASSERT_SAME(a_stall_busy, clock, reset,
      req_stall,
      in_valid_ff && out_valid_ff && rsp_stall,
      "input stalled without a full pipeline")

endmodule

`default_nettype wire
